FILE: src/pia_pkg.sv
// Shared types, codes, constants and control register helpers of the interface adapter.
package pia_pkg;

    // Command codes of one input beat.
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_EDGE  = 2'd2;

    // Register addresses.
    localparam logic [1:0] ADDR_PORT_A = 2'd0;
    localparam logic [1:0] ADDR_CTRL_A = 2'd1;
    localparam logic [1:0] ADDR_PORT_B = 2'd2;
    localparam logic [1:0] ADDR_CTRL_B = 2'd3;

    // Edge line codes.
    localparam logic LINE_C1A = 1'b0;
    localparam logic LINE_C1B = 1'b1;

    // Control register bit fields and mode codes.
    localparam logic [7:0] C_IRQ1_MASK   = 8'h81;
    localparam logic [7:0] C_IRQ2_MASK   = 8'h68;
    localparam logic [7:0] C_IRQ2_VALUE  = 8'h48;
    localparam logic [7:0] C_MODE_MASK   = 8'h38;
    localparam logic [7:0] C_MODE_LOW    = 8'h30;
    localparam logic [7:0] C_MODE_HIGH   = 8'h38;
    localparam logic [7:0] C_MODE_TOGGLE = 8'h20;
    localparam logic [7:0] C_MODE_PULSE  = 8'h28;
    localparam logic [7:0] C_OUT_MASK    = 8'h30;
    localparam logic [7:0] C_OUT_MANUAL  = 8'h30;
    localparam logic [7:0] C_OUT_HSHAKE  = 8'h20;
    localparam logic [7:0] C_KEEP_MASK   = 8'hc0;
    localparam logic [7:0] C_VALUE_MASK  = 8'h3f;
    localparam logic [7:0] C_BIT6_CLEAR  = 8'hbf;
    localparam logic [7:0] C_FLAG1_SET   = 8'h80;
    localparam logic [7:0] C_EDGE_POL    = 8'h02;
    localparam logic [7:0] C_FLAG_CLEAR  = 8'h3f;
    localparam logic [7:0] C_BIT5        = 8'h20;
    localparam logic [7:0] C_SEL_OUTPUT  = 8'h04;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] address;
        logic [7:0] write_data;
        logic       peek;
        logic       rmw_double;
        logic [7:0] port_a_pins;
        logic [7:0] port_b_pins;
        logic       edge_line;
        logic       edge_rising;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic       ca2_level;
        logic       cb2_level;
        logic       cb2_strobe;
        logic [7:0] port_a_drive;
        logic [7:0] port_b_drive;
    } t_result;

    typedef struct packed {
        logic [7:0] ctrl;
        logic       line;
    } t_ctrl_upd;

    function automatic logic f_side_irq(logic [7:0] c);
        return ((c & C_IRQ1_MASK) == C_IRQ1_MASK) || ((c & C_IRQ2_MASK) == C_IRQ2_VALUE);
    endfunction

    // One control register write: new control value and the CA2/CB2 level after it.
    function automatic t_ctrl_upd f_write_control(logic [7:0] old, logic [7:0] v, logic line);
        t_ctrl_upd u;
        u.line = line;
        if ((v & C_MODE_MASK) == C_MODE_LOW) begin
            u.line = 1'b0;
        end else if ((v & C_MODE_MASK) == C_MODE_HIGH) begin
            u.line = 1'b1;
        end else if ((old & C_OUT_MASK) == C_OUT_MANUAL) begin
            u.line = 1'b1;
        end
        u.ctrl = (old & C_KEEP_MASK) | (v & C_VALUE_MASK);
        if ((u.ctrl & C_BIT5) != 8'h00) begin
            u.ctrl = u.ctrl & C_BIT6_CLEAR;
        end
        return u;
    endfunction

endpackage

FILE: src/pia_in_stage.sv
// Input register: holds one accepted beat until the core takes it.
module pia_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pia_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output pia_pkg::t_item o_item
);

    logic           r_valid;
    pia_pkg::t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: src/pia_core.sv
// Adapter registers and the single-pass update that one beat applies to them.
module pia_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  pia_pkg::t_item   i_item,
    output pia_pkg::t_result o_result
);

    logic [7:0] r_control_a, n_control_a;
    logic [7:0] r_control_b, n_control_b;
    logic [7:0] r_direction_a, n_direction_a;
    logic [7:0] r_direction_b, n_direction_b;
    logic [7:0] r_output_a, n_output_a;
    logic [7:0] r_output_b, n_output_b;
    logic       r_ca2, n_ca2;
    logic       r_cb2, n_cb2;
    logic [7:0] r_last_read, n_last_read;

    logic [7:0]         rd;
    logic               strobe;
    pia_pkg::t_ctrl_upd first_upd;
    pia_pkg::t_ctrl_upd second_upd;
    logic [7:0]         old_ctrl;
    logic               old_line;

    // A read-modify-write stores the last read byte first into a control register;
    // for the port registers only the second store is applied.
    always_comb begin
        old_ctrl = (i_item.address == pia_pkg::ADDR_CTRL_A) ? r_control_a : r_control_b;
        old_line = (i_item.address == pia_pkg::ADDR_CTRL_A) ? r_ca2 : r_cb2;
        first_upd = pia_pkg::f_write_control(old_ctrl, r_last_read, old_line);
        if (!i_item.rmw_double) begin
            first_upd.ctrl = old_ctrl;
            first_upd.line = old_line;
        end
        second_upd = pia_pkg::f_write_control(first_upd.ctrl, i_item.write_data,
                                              first_upd.line);
    end

    always_comb begin
        n_control_a   = r_control_a;
        n_control_b   = r_control_b;
        n_direction_a = r_direction_a;
        n_direction_b = r_direction_b;
        n_output_a    = r_output_a;
        n_output_b    = r_output_b;
        n_ca2         = r_ca2;
        n_cb2         = r_cb2;
        n_last_read   = r_last_read;
        rd            = 8'h00;
        strobe        = 1'b0;
        unique case (i_item.command)
            pia_pkg::CMD_READ: begin
                unique case (i_item.address)
                    pia_pkg::ADDR_PORT_A: begin
                        if ((r_control_a & pia_pkg::C_SEL_OUTPUT) != 8'h00) begin
                            if (!i_item.peek) begin
                                n_control_a = r_control_a & pia_pkg::C_FLAG_CLEAR;
                            end
                            rd = i_item.port_a_pins;
                        end else begin
                            rd = r_direction_a;
                        end
                    end
                    pia_pkg::ADDR_PORT_B: begin
                        if ((r_control_b & pia_pkg::C_SEL_OUTPUT) != 8'h00) begin
                            if (!i_item.peek) begin
                                n_control_b = r_control_b & pia_pkg::C_FLAG_CLEAR;
                            end
                            rd = (i_item.port_b_pins & ~r_direction_b)
                               | (r_output_b & r_direction_b);
                        end else begin
                            rd = r_direction_b;
                        end
                    end
                    pia_pkg::ADDR_CTRL_A: rd = r_control_a;
                    default:              rd = r_control_b;
                endcase
                n_last_read = rd;
            end
            pia_pkg::CMD_WRITE: begin
                unique case (i_item.address)
                    pia_pkg::ADDR_PORT_A: begin
                        if ((r_control_a & pia_pkg::C_SEL_OUTPUT) != 8'h00) begin
                            n_output_a = i_item.write_data;
                        end else begin
                            n_direction_a = i_item.write_data;
                        end
                    end
                    pia_pkg::ADDR_PORT_B: begin
                        if ((r_control_b & pia_pkg::C_SEL_OUTPUT) != 8'h00) begin
                            n_output_b = i_item.write_data;
                        end else begin
                            n_direction_b = i_item.write_data;
                        end
                        if ((r_control_b & pia_pkg::C_OUT_MASK) == pia_pkg::C_OUT_HSHAKE) begin
                            n_cb2 = 1'b0;
                            if ((r_control_b & pia_pkg::C_MODE_MASK) == pia_pkg::C_MODE_PULSE) begin
                                n_cb2  = 1'b1;
                                strobe = 1'b1;
                            end
                        end
                    end
                    pia_pkg::ADDR_CTRL_A: begin
                        n_control_a = second_upd.ctrl;
                        n_ca2       = second_upd.line;
                    end
                    default: begin
                        n_control_b = second_upd.ctrl;
                        n_cb2       = second_upd.line;
                    end
                endcase
            end
            pia_pkg::CMD_EDGE: begin
                if (i_item.edge_line == pia_pkg::LINE_C1A) begin
                    if (((r_control_a & pia_pkg::C_EDGE_POL) != 8'h00) == i_item.edge_rising) begin
                        n_control_a = r_control_a | pia_pkg::C_FLAG1_SET;
                        if ((r_control_a & pia_pkg::C_MODE_MASK) == pia_pkg::C_MODE_TOGGLE) begin
                            n_ca2 = 1'b1;
                        end
                    end
                end else begin
                    if (((r_control_b & pia_pkg::C_EDGE_POL) != 8'h00) == i_item.edge_rising) begin
                        n_control_b = r_control_b | pia_pkg::C_FLAG1_SET;
                        if ((r_control_b & pia_pkg::C_MODE_MASK) == pia_pkg::C_MODE_TOGGLE) begin
                            n_cb2 = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.read_data    = rd;
        o_result.irq          = pia_pkg::f_side_irq(n_control_a)
                              || pia_pkg::f_side_irq(n_control_b);
        o_result.ca2_level    = n_ca2;
        o_result.cb2_level    = n_cb2;
        o_result.cb2_strobe   = strobe;
        o_result.port_a_drive = n_output_a | ~n_direction_a;
        o_result.port_b_drive = n_output_b | ~n_direction_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control_a   <= 8'h00;
            r_control_b   <= 8'h00;
            r_direction_a <= 8'h00;
            r_direction_b <= 8'h00;
            r_output_a    <= 8'hff;
            r_output_b    <= 8'hff;
            r_ca2         <= 1'b1;
            r_cb2         <= 1'b1;
            r_last_read   <= 8'h00;
        end else if (i_step) begin
            r_control_a   <= n_control_a;
            r_control_b   <= n_control_b;
            r_direction_a <= n_direction_a;
            r_direction_b <= n_direction_b;
            r_output_a    <= n_output_a;
            r_output_b    <= n_output_b;
            r_ca2         <= n_ca2;
            r_cb2         <= n_cb2;
            r_last_read   <= n_last_read;
        end
    end

endmodule

FILE: src/pia_out_stage.sv
// Result register: holds one result beat until downstream takes it.
module pia_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  pia_pkg::t_result i_result,
    output logic             o_valid,
    input  logic             i_ready,
    output pia_pkg::t_result o_result
);

    logic             r_valid;
    pia_pkg::t_result r_result;

    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: src/pia_parallel_port_interface.sv
// Top level of the two-port parallel interface adapter.
//
//   Channel   Direction   Handshake                   Beat carries
//   input     in          i_in_valid / o_in_ready     bus access or CA1/CB1 edge event
//   result    out         o_out_valid / i_out_ready   read data, interrupt, CA2/CB2, pin drive
//
// Every input beat yields exactly one result beat. A beat is captured in an input
// register; when the result register is empty or being emptied, the core applies
// it to the adapter registers and loads the result register. Without a stall on
// the result side the sustained rate is one beat per clock. While a result waits
// to be taken the input register still takes one more beat, so a stall on the
// result side reaches the input side only one beat later. Reset (i_rst_n low at
// a clock edge) empties both stages and returns the adapter registers to their
// power-on values: controls and directions clear, outputs all ones, CA2/CB2 high.
module pia_parallel_port_interface (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_command,
    input  logic [1:0] i_address,
    input  logic [7:0] i_write_data,
    input  logic       i_peek,
    input  logic       i_rmw_double,
    input  logic [7:0] i_port_a_pins,
    input  logic [7:0] i_port_b_pins,
    input  logic       i_edge_line,
    input  logic       i_edge_rising,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_data,
    output logic       o_irq,
    output logic       o_ca2_level,
    output logic       o_cb2_level,
    output logic       o_cb2_strobe,
    output logic [7:0] o_port_a_drive,
    output logic [7:0] o_port_b_drive
);

    pia_pkg::t_item   in_item;
    pia_pkg::t_item   held_item;
    pia_pkg::t_result core_result;
    pia_pkg::t_result out_result;
    logic             held_valid;
    logic             advance;

    // Gather the input ports into one beat.
    assign in_item.command     = i_command;
    assign in_item.address     = i_address;
    assign in_item.write_data  = i_write_data;
    assign in_item.peek        = i_peek;
    assign in_item.rmw_double  = i_rmw_double;
    assign in_item.port_a_pins = i_port_a_pins;
    assign in_item.port_b_pins = i_port_b_pins;
    assign in_item.edge_line   = i_edge_line;
    assign in_item.edge_rising = i_edge_rising;

    // The held beat moves on whenever the result register is empty or is
    // being emptied in this cycle; the adapter registers change at the same edge.
    assign advance = held_valid && (!o_out_valid || i_out_ready);

    pia_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    pia_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (held_item),
        .o_result (core_result)
    );

    pia_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (core_result),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_read_data    = out_result.read_data;
    assign o_irq          = out_result.irq;
    assign o_ca2_level    = out_result.ca2_level;
    assign o_cb2_level    = out_result.cb2_level;
    assign o_cb2_strobe   = out_result.cb2_strobe;
    assign o_port_a_drive = out_result.port_a_drive;
    assign o_port_b_drive = out_result.port_b_drive;

endmodule
